@@ design/hand_tracking_packet_parser_unit_defines.svh @@
// ----------------------------------------------------------------------------
// hand tracking packet parser assertion macros
// shared property forms for the parser checks, clocked on clk_i, off in reset
// ----------------------------------------------------------------------------
`ifndef HAND_TRACKING_PACKET_PARSER_UNIT_DEFINES_SVH
`define HAND_TRACKING_PACKET_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define HTPP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("htpp check failed");

// next-cycle implication
`define HTPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("htpp check failed");

`endif

@@ design/htpp_pkg.sv @@
// ----------------------------------------------------------------------------
// hand tracking packet parser package
// field layout, size limits and result codes of the parser
// ----------------------------------------------------------------------------
`default_nettype none

package htpp_pkg;

  // datagram size limits
  localparam int unsigned MAX_HANDS        = 8;
  localparam int unsigned MAX_FINGERS      = 5;
  localparam int unsigned BONES_PER_FINGER = 4;

  // ascii '0', subtracted from the sensor byte
  localparam logic [31:0] ASCII_ZERO = 32'd48;

  // field kinds, same numbering as the parse phases that produce them
  localparam logic [3:0] KIND_SENSOR   = 4'd0;
  localparam logic [3:0] KIND_HCOUNT   = 4'd1;
  localparam logic [3:0] KIND_HID      = 4'd2;
  localparam logic [3:0] KIND_SIDE     = 4'd3;
  localparam logic [3:0] KIND_CONF     = 4'd4;
  localparam logic [3:0] KIND_GRAB     = 4'd5;
  localparam logic [3:0] KIND_FCOUNT   = 4'd6;
  localparam logic [3:0] KIND_HPOS     = 4'd7;
  localparam logic [3:0] KIND_HDIR     = 4'd8;
  localparam logic [3:0] KIND_BPOS     = 4'd9;
  localparam logic [3:0] KIND_BDIR     = 4'd10;
  localparam logic [3:0] KIND_BLEN     = 4'd11;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_SIDE      = 2'd1;
  localparam logic [1:0] ERR_FINGERS   = 2'd2;
  localparam logic [1:0] ERR_HANDS     = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [6:0]  hand_index;
    logic [2:0]  finger_index;
    logic [1:0]  bone_index;
    logic [1:0]  component;
    logic [31:0] value;
    logic [1:0]  error_code;
    logic        packet_done;
  } out_req_t;

endpackage

`default_nettype wire

@@ design/hand_tracking_packet_parser_unit.sv @@
// ----------------------------------------------------------------------------
// hand tracking packet parser unit
// byte-serial decoder of a hand-tracking datagram, one field request per
// completed field
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+----------------------------
//   in      | in  | in_valid_i / in_ready_o   | in_data_i   (htpp_pkg::in_req_t)
//   out     | out | out_valid_o / out_ready_i | out_data_o  (htpp_pkg::out_req_t)
//
// one byte per cycle if not stalled: the parse state and the result register
// are updated in the same cycle a byte is taken, so its result shows next
// cycle; in_ready_o is low only while a result sits in the output register
// and the consumer stalls it; out_ready_i feeds in_ready_o combinationally
// reset clears the parse state to waiting and empties the output register
// bytes that finish no field are consumed without a result
`default_nettype none

module hand_tracking_packet_parser_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire htpp_pkg::in_req_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output htpp_pkg::out_req_t    out_data_o
);

`include "hand_tracking_packet_parser_unit_defines.svh"

  // parse phases (the field kind a word phase produces uses the same code)
  localparam logic [3:0] PH_WAIT   = 4'd0;
  localparam logic [3:0] PH_HCOUNT = 4'd1;
  localparam logic [3:0] PH_HID    = 4'd2;
  localparam logic [3:0] PH_SIDE   = 4'd3;
  localparam logic [3:0] PH_CONF   = 4'd4;
  localparam logic [3:0] PH_GRAB   = 4'd5;
  localparam logic [3:0] PH_FCOUNT = 4'd6;
  localparam logic [3:0] PH_HPOS   = 4'd7;
  localparam logic [3:0] PH_HDIR   = 4'd8;
  localparam logic [3:0] PH_BPOS   = 4'd9;
  localparam logic [3:0] PH_BDIR   = 4'd10;
  localparam logic [3:0] PH_BLEN   = 4'd11;

  // parse state
  logic [3:0]  phase_q, phase_d;
  logic [1:0]  byte_cnt_q, byte_cnt_d;
  logic [23:0] word_shift_q, word_shift_d;
  logic [6:0]  hands_total_q, hands_total_d;
  logic [6:0]  hand_cnt_q, hand_cnt_d;
  logic [2:0]  fingers_total_q, fingers_total_d;
  logic [2:0]  finger_cnt_q, finger_cnt_d;
  logic [1:0]  bone_cnt_q, bone_cnt_d;
  logic [1:0]  comp_cnt_q, comp_cnt_d;

  // output register
  logic                out_valid_q, out_valid_d;
  htpp_pkg::out_req_t  out_data_q, out_data_d;

  logic                in_fire;
  logic [7:0]          b;
  logic [7:0]          count_byte;    // count with high bit set read as zero
  logic [31:0]         word;
  logic                last_hand;
  logic                last_finger;
  logic                last_bone;
  logic                last_comp;
  logic                res_valid;
  htpp_pkg::out_req_t  res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign b          = in_data_i.data_byte;
  assign count_byte = b[7] ? 8'd0 : b;
  assign word       = {word_shift_q, b};

  // end-of-loop tests, widened by one bit so the +1 cannot wrap
  assign last_hand   = ({1'b0, hand_cnt_q} + 8'd1) >= {1'b0, hands_total_q};
  assign last_finger = ({1'b0, finger_cnt_q} + 4'd1) >= {1'b0, fingers_total_q};
  assign last_bone   = ({1'b0, bone_cnt_q} + 3'd1) >= 3'(htpp_pkg::BONES_PER_FINGER);
  assign last_comp   = comp_cnt_q >= 2'd2;

  // next state and result for the byte at the input
  always_comb begin
    phase_d         = phase_q;
    byte_cnt_d      = byte_cnt_q;
    word_shift_d    = word_shift_q;
    hands_total_d   = hands_total_q;
    hand_cnt_d      = hand_cnt_q;
    fingers_total_d = fingers_total_q;
    finger_cnt_d    = finger_cnt_q;
    bone_cnt_d      = bone_cnt_q;
    comp_cnt_d      = comp_cnt_q;

    res_valid        = 1'b0;
    res.field_kind   = phase_q;
    res.hand_index   = hand_cnt_q;
    res.finger_index = 3'd0;
    res.bone_index   = 2'd0;
    res.component    = 2'd0;
    res.value        = 32'd0;
    res.error_code   = htpp_pkg::ERR_NONE;
    res.packet_done  = 1'b0;

    if (in_data_i.packet_start) begin
      // start always restarts, dropping a datagram in progress
      phase_d         = PH_HCOUNT;
      byte_cnt_d      = 2'd0;
      word_shift_d    = 24'd0;
      hands_total_d   = 7'd0;
      hand_cnt_d      = 7'd0;
      fingers_total_d = 3'd0;
      finger_cnt_d    = 3'd0;
      bone_cnt_d      = 2'd0;
      comp_cnt_d      = 2'd0;
      res_valid       = 1'b1;
      res.field_kind  = htpp_pkg::KIND_SENSOR;
      res.hand_index  = 7'd0;
      res.value       = {{24{b[7]}}, b} - htpp_pkg::ASCII_ZERO;
    end else begin
      case (phase_q)
        PH_HCOUNT: begin
          res_valid      = 1'b1;
          res.hand_index = 7'd0;
          res.value      = {24'd0, count_byte};
          if (count_byte > 8'(htpp_pkg::MAX_HANDS)) begin
            phase_d         = PH_WAIT;
            res.error_code  = htpp_pkg::ERR_HANDS;
            res.packet_done = 1'b1;
          end else begin
            hands_total_d = count_byte[6:0];
            hand_cnt_d    = 7'd0;
            byte_cnt_d    = 2'd0;
            if (count_byte == 8'd0) begin
              phase_d         = PH_WAIT;
              res.packet_done = 1'b1;
            end else begin
              phase_d = PH_HID;
            end
          end
        end
        PH_SIDE: begin
          res_valid      = 1'b1;
          res.value      = {24'd0, b};
          res.error_code = (b > 8'd1) ? htpp_pkg::ERR_SIDE : htpp_pkg::ERR_NONE;
          phase_d        = PH_CONF;
          byte_cnt_d     = 2'd0;
        end
        PH_FCOUNT: begin
          res_valid = 1'b1;
          res.value = {24'd0, count_byte};
          if (count_byte > 8'(htpp_pkg::MAX_FINGERS)) begin
            phase_d         = PH_WAIT;
            res.error_code  = htpp_pkg::ERR_FINGERS;
            res.packet_done = 1'b1;
          end else begin
            fingers_total_d = count_byte[2:0];
            finger_cnt_d    = 3'd0;
            bone_cnt_d      = 2'd0;
            comp_cnt_d      = 2'd0;
            byte_cnt_d      = 2'd0;
            phase_d         = PH_HPOS;
          end
        end
        PH_HID, PH_CONF, PH_GRAB, PH_HPOS, PH_HDIR, PH_BPOS, PH_BDIR, PH_BLEN: begin
          if (byte_cnt_q != 2'd3) begin
            // collect the leading bytes of a big-endian word
            word_shift_d = {word_shift_q[15:0], b};
            byte_cnt_d   = byte_cnt_q + 2'd1;
          end else begin
            res_valid    = 1'b1;
            res.value    = word;
            byte_cnt_d   = 2'd0;
            word_shift_d = 24'd0;
            if (phase_q inside {[PH_BPOS:PH_BLEN]}) begin
              res.finger_index = finger_cnt_q;
              res.bone_index   = bone_cnt_q;
            end
            if (phase_q inside {[PH_HPOS:PH_BDIR]}) begin
              res.component = comp_cnt_q;
            end
            case (phase_q)
              PH_HID:  phase_d = PH_SIDE;
              PH_CONF: phase_d = PH_GRAB;
              PH_GRAB: phase_d = PH_FCOUNT;
              PH_HPOS, PH_BPOS, PH_BDIR: begin
                if (last_comp) begin
                  comp_cnt_d = 2'd0;
                  phase_d    = phase_q + 4'd1;
                end else begin
                  comp_cnt_d = comp_cnt_q + 2'd1;
                end
              end
              PH_HDIR: begin
                if (last_comp) begin
                  comp_cnt_d = 2'd0;
                  if (fingers_total_q == 3'd0) begin
                    // hand without fingers ends after its direction
                    if (last_hand) begin
                      phase_d         = PH_WAIT;
                      res.packet_done = 1'b1;
                    end else begin
                      hand_cnt_d = hand_cnt_q + 7'd1;
                      phase_d    = PH_HID;
                    end
                  end else begin
                    finger_cnt_d = 3'd0;
                    bone_cnt_d   = 2'd0;
                    phase_d      = PH_BPOS;
                  end
                end else begin
                  comp_cnt_d = comp_cnt_q + 2'd1;
                end
              end
              default: begin
                // bone length closes a bone, maybe a finger and a hand
                if (last_bone) begin
                  bone_cnt_d = 2'd0;
                  if (last_finger) begin
                    finger_cnt_d = 3'd0;
                    if (last_hand) begin
                      phase_d         = PH_WAIT;
                      res.packet_done = 1'b1;
                    end else begin
                      hand_cnt_d = hand_cnt_q + 7'd1;
                      phase_d    = PH_HID;
                    end
                  end else begin
                    finger_cnt_d = finger_cnt_q + 3'd1;
                    phase_d      = PH_BPOS;
                  end
                end else begin
                  bone_cnt_d = bone_cnt_q + 2'd1;
                  phase_d    = PH_BPOS;
                end
              end
            endcase
          end
        end
        default: begin
          // waiting, or an unused phase code: byte is dropped
        end
      endcase
    end
  end

  // output register load
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_fire) begin
      out_valid_d = res_valid;
      out_data_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_WAIT;
      byte_cnt_q      <= 2'd0;
      word_shift_q    <= 24'd0;
      hands_total_q   <= 7'd0;
      hand_cnt_q      <= 7'd0;
      fingers_total_q <= 3'd0;
      finger_cnt_q    <= 3'd0;
      bone_cnt_q      <= 2'd0;
      comp_cnt_q      <= 2'd0;
      out_valid_q     <= 1'b0;
    end else if (in_fire) begin
      phase_q         <= phase_d;
      byte_cnt_q      <= byte_cnt_d;
      word_shift_q    <= word_shift_d;
      hands_total_q   <= hands_total_d;
      hand_cnt_q      <= hand_cnt_d;
      fingers_total_q <= fingers_total_d;
      finger_cnt_q    <= finger_cnt_d;
      bone_cnt_q      <= bone_cnt_d;
      comp_cnt_q      <= comp_cnt_d;
      out_valid_q     <= out_valid_d;
    end else begin
      out_valid_q     <= out_valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a result that closes the datagram leaves the parser waiting
  `HTPP_ASSERT_NOW(a_done_waits, out_valid_q && out_data_q.packet_done, phase_q == PH_WAIT)

  // errors come only from side and count fields
  `HTPP_ASSERT_NOW(a_err_kind, out_valid_q && out_data_q.error_code != htpp_pkg::ERR_NONE,
    out_data_q.field_kind == htpp_pkg::KIND_SIDE ||
    out_data_q.field_kind == htpp_pkg::KIND_FCOUNT ||
    out_data_q.field_kind == htpp_pkg::KIND_HCOUNT)

  // stray bytes while waiting give no result
  `HTPP_ASSERT_NEXT(a_wait_quiet, in_fire && !in_data_i.packet_start && phase_q == PH_WAIT,
    !out_valid_q)

  // hand counter stays inside the announced hand count
  `HTPP_ASSERT_NOW(a_hand_range, phase_q >= PH_HID && phase_q <= PH_BLEN,
    hand_cnt_q < hands_total_q)

  // finger counter stays inside the announced finger count during bones
  `HTPP_ASSERT_NOW(a_finger_range, phase_q >= PH_BPOS && phase_q <= PH_BLEN,
    finger_cnt_q < fingers_total_q)

endmodule

`default_nettype wire

@@ bench/htpp_field_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hand tracking parser field checker
// watches both channels, runs its own byte-serial decoder on every accepted
// byte and compares each field request with the oldest decoded field
// ----------------------------------------------------------------------------
module htpp_field_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  htpp_pkg::in_req_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  htpp_pkg::out_req_t out_data_i,
  output int                 mismatch_count_o,
  output int                 pending_count_o,
  output int                 fields_checked_o
);
  import htpp_pkg::*;

  localparam logic [3:0] PHASE_WAIT = 4'd0;

  // decoder state
  logic [3:0]  cur_phase;
  logic [1:0]  bytes_held;
  logic [23:0] word_bits;
  logic [6:0]  hand_limit;
  logic [6:0]  hand_num;
  logic [2:0]  finger_limit;
  logic [2:0]  finger_pos;
  logic [1:0]  bone_num;
  logic [1:0]  axis_num;

  out_req_t pending_fields[$];

  task automatic clear_parse_state();
    cur_phase    = PHASE_WAIT;
    bytes_held   = '0;
    word_bits    = '0;
    hand_limit   = '0;
    hand_num     = '0;
    finger_limit = '0;
    finger_pos   = '0;
    bone_num     = '0;
    axis_num     = '0;
  endtask

  task automatic expect_field(logic [3:0] kind, logic [6:0] hand, logic [2:0] fin,
                              logic [1:0] bone, logic [1:0] comp, logic [31:0] value,
                              logic [1:0] err, logic done);
    out_req_t f;
    f.field_kind   = kind;
    f.hand_index   = hand;
    f.finger_index = fin;
    f.bone_index   = bone;
    f.component    = comp;
    f.value        = value;
    f.error_code   = err;
    f.packet_done  = done;
    pending_fields.insert(pending_fields.size(), f);
  endtask

  // closes the current hand, returns 1 when it was the last one
  function automatic logic close_hand();
    if (int'(hand_num) + 1 >= int'(hand_limit)) begin
      cur_phase = PHASE_WAIT;
      return 1'b1;
    end
    hand_num  = hand_num + 7'd1;
    cur_phase = KIND_HID;
    return 1'b0;
  endfunction

  task automatic decode_byte(input in_req_t req);
    logic [7:0]  b;
    logic [7:0]  count;
    logic [3:0]  ph;
    logic [6:0]  hand;
    logic [2:0]  fin;
    logic [1:0]  bone;
    logic [1:0]  comp;
    logic [31:0] word;
    logic        done;
    b    = req.data_byte;
    ph   = cur_phase;
    hand = hand_num;
    fin  = '0;
    bone = '0;
    comp = '0;
    done = 1'b0;
    if (req.packet_start) begin
      clear_parse_state();
      cur_phase = KIND_HCOUNT;
      expect_field(KIND_SENSOR, '0, '0, '0, '0, {{24{b[7]}}, b} - ASCII_ZERO, ERR_NONE, 1'b0);
    end else if (ph == PHASE_WAIT || ph > KIND_BLEN) begin
      // ignored
    end else if (ph == KIND_HCOUNT) begin
      count = b[7] ? 8'd0 : b;
      if (count > MAX_HANDS) begin
        cur_phase = PHASE_WAIT;
        expect_field(KIND_HCOUNT, '0, '0, '0, '0, {24'd0, count}, ERR_HANDS, 1'b1);
      end else begin
        hand_limit = count[6:0];
        hand_num   = '0;
        bytes_held = '0;
        done       = (count == 8'd0);
        cur_phase  = done ? PHASE_WAIT : KIND_HID;
        expect_field(KIND_HCOUNT, '0, '0, '0, '0, {24'd0, count}, ERR_NONE, done);
      end
    end else if (ph == KIND_SIDE) begin
      cur_phase  = KIND_CONF;
      bytes_held = '0;
      expect_field(KIND_SIDE, hand, '0, '0, '0, {24'd0, b},
                   (b > 8'd1) ? ERR_SIDE : ERR_NONE, 1'b0);
    end else if (ph == KIND_FCOUNT) begin
      count = b[7] ? 8'd0 : b;
      if (count > MAX_FINGERS) begin
        cur_phase = PHASE_WAIT;
        expect_field(KIND_FCOUNT, hand, '0, '0, '0, {24'd0, count}, ERR_FINGERS, 1'b1);
      end else begin
        finger_limit = count[2:0];
        finger_pos   = '0;
        bone_num     = '0;
        axis_num     = '0;
        bytes_held   = '0;
        cur_phase    = KIND_HPOS;
        expect_field(KIND_FCOUNT, hand, '0, '0, '0, {24'd0, count}, ERR_NONE, 1'b0);
      end
    end else if (bytes_held < 2'd3) begin
      word_bits  = {word_bits[15:0], b};
      bytes_held = bytes_held + 2'd1;
    end else begin
      // last byte of a big-endian word
      word       = {word_bits, b};
      bytes_held = '0;
      word_bits  = '0;
      if (ph inside {[KIND_BPOS:KIND_BLEN]}) begin
        fin  = finger_pos;
        bone = bone_num;
      end
      if (ph inside {[KIND_HPOS:KIND_BDIR]}) comp = axis_num;
      case (ph)
        KIND_HID:  cur_phase = KIND_SIDE;
        KIND_CONF: cur_phase = KIND_GRAB;
        KIND_GRAB: cur_phase = KIND_FCOUNT;
        KIND_HPOS, KIND_BPOS, KIND_BDIR: begin
          if (axis_num >= 2'd2) begin
            axis_num  = '0;
            cur_phase = ph + 4'd1;
          end else begin
            axis_num = axis_num + 2'd1;
          end
        end
        KIND_HDIR: begin
          if (axis_num >= 2'd2) begin
            axis_num = '0;
            if (finger_limit == 3'd0) begin
              done = close_hand();
            end else begin
              finger_pos = '0;
              bone_num   = '0;
              cur_phase  = KIND_BPOS;
            end
          end else begin
            axis_num = axis_num + 2'd1;
          end
        end
        KIND_BLEN: begin
          if (int'(bone_num) + 1 >= BONES_PER_FINGER) begin
            bone_num = '0;
            if (int'(finger_pos) + 1 >= int'(finger_limit)) begin
              finger_pos = '0;
              done       = close_hand();
            end else begin
              finger_pos = finger_pos + 3'd1;
              cur_phase  = KIND_BPOS;
            end
          end else begin
            bone_num  = bone_num + 2'd1;
            cur_phase = KIND_BPOS;
          end
        end
        default: ;
      endcase
      expect_field(ph, hand, fin, bone, comp, word, ERR_NONE, done);
    end
  endtask

  // one line per mismatch, and the count
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count_o++;
    $display("%t mismatch: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic check_field(input out_req_t got);
    out_req_t want;
    if (pending_fields.size() == 0) begin
      report_mismatch("field request with none pending, kind", 32'(got.field_kind), 32'd0);
    end else begin
      want = pending_fields.pop_front();
      fields_checked_o++;
      if (got.field_kind !== want.field_kind)
        report_mismatch("field_kind", 32'(got.field_kind), 32'(want.field_kind));
      if (got.hand_index !== want.hand_index)
        report_mismatch("hand_index", 32'(got.hand_index), 32'(want.hand_index));
      if (got.finger_index !== want.finger_index)
        report_mismatch("finger_index", 32'(got.finger_index), 32'(want.finger_index));
      if (got.bone_index !== want.bone_index)
        report_mismatch("bone_index", 32'(got.bone_index), 32'(want.bone_index));
      if (got.component !== want.component)
        report_mismatch("component", 32'(got.component), 32'(want.component));
      if (got.value !== want.value)
        report_mismatch("value", got.value, want.value);
      if (got.error_code !== want.error_code)
        report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
      if (got.packet_done !== want.packet_done)
        report_mismatch("packet_done", 32'(got.packet_done), 32'(want.packet_done));
    end
  endtask

  // older results leave before the byte taken at the same edge adds its own
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse_state();
      pending_fields.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
      fields_checked_o = 0;
    end else begin
      if (out_valid_i === 1'b1 && out_ready_i) check_field(out_data_i);
      if (in_valid_i && in_ready_i === 1'b1) decode_byte(in_data_i);
      pending_count_o = pending_fields.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hand tracking packet parser testbench
// feeds directed corner bytes, then random datagrams, cut datagrams and loose
// bytes, with random idle and stall bursts; a checker decodes the same bytes
// and compares every field request
// ----------------------------------------------------------------------------
module tb;
  import htpp_pkg::*;

  // datagram bytes in the random part, and the calm tail with no idling
  localparam int RANDOM_BYTES = 1500;
  localparam int CALM_TAIL    = 150;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  in_req_t  in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  out_req_t out_data_o;

  int mismatch_count;
  int pending_count;
  int fields_checked;

  // whole byte stream is built before reset is released
  in_req_t byte_stream[$];
  // one datagram under construction, so it can be cut short
  in_req_t frame[$];
  int      datagrams      = 0;
  int      cut_datagrams  = 0;
  int      datagram_bytes = 0;
  // no idling on either side once set
  logic    calm           = 1'b0;

  always #5 clk_i = ~clk_i;

  hand_tracking_packet_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  htpp_field_checker u_field_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .fields_checked_o (fields_checked)
  );

  // byte straight into the stream, outside any datagram
  task automatic add_raw(input logic [7:0] b, input logic start);
    in_req_t r;
    r.data_byte    = b;
    r.packet_start = start;
    byte_stream.insert(byte_stream.size(), r);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic start);
    in_req_t r;
    r.data_byte    = b;
    r.packet_start = start;
    frame.insert(frame.size(), r);
  endtask

  // words are raw patterns to the parser, so any four bytes will do
  task automatic push_word();
    repeat (4) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // builds one datagram into frame; a broken count byte ends it where the
  // parser would give up, and the big one holds the most hands and one hand
  // with the most fingers
  task automatic build_datagram(input logic big);
    logic [7:0] count;
    int         hands;
    int         fingers;
    frame.delete();
    push_byte(8'($urandom_range(0, 255)), 1'b1);
    if (big)
      count = 8'(MAX_HANDS);
    else if ($urandom_range(0, 15) == 0)
      count = 8'($urandom_range(0, 255));
    else if ($urandom_range(0, 4) == 0)
      count = 8'($urandom_range(3, MAX_HANDS));
    else
      count = 8'($urandom_range(0, 2));
    push_byte(count, 1'b0);
    hands = count[7] ? 0 : int'(count);
    if (hands > MAX_HANDS) return;
    for (int h = 0; h < hands; h++) begin
      push_word();
      // side code: mostly left or right, sometimes junk
      if ($urandom_range(0, 9) == 0)
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      else
        push_byte(8'($urandom_range(0, 1)), 1'b0);
      push_word();
      push_word();
      // finger count: mostly none or one, since each finger costs 112 bytes
      if (big)
        count = (h == MAX_HANDS - 1) ? 8'(MAX_FINGERS) : 8'd0;
      else if ($urandom_range(0, 19) == 0)
        count = 8'($urandom_range(0, 255));
      else if ($urandom_range(0, 9) == 0)
        count = 8'($urandom_range(2, MAX_FINGERS));
      else
        count = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0;
      push_byte(count, 1'b0);
      fingers = count[7] ? 0 : int'(count);
      if (fingers > MAX_FINGERS) return;
      // hand position and direction, then seven words per bone
      repeat (6 + fingers * BONES_PER_FINGER * 7) push_word();
    end
  endtask

  // moves the first keep bytes of frame into the stream
  task automatic commit_frame(input int keep);
    for (int i = 0; i < keep; i++) byte_stream.insert(byte_stream.size(), frame[i]);
    datagram_bytes += keep;
    datagrams++;
  endtask

  // request sender
  initial begin
    int pick;
    int quiet_from;

    // directed corners
    add_raw(8'hA5, 1'b0);                          // byte while waiting, dropped
    add_raw(8'h00, 1'b1);                          // lowest sensor byte
    add_raw(8'h00, 1'b0);                          // no hands, done at once
    add_raw(8'hFF, 1'b1);                          // sensor byte with sign bit
    add_raw(8'h80, 1'b0);                          // count with high bit reads as zero
    add_raw(8'h30, 1'b1);                          // sensor '0'
    add_raw(8'h09, 1'b0);                          // one hand over the limit
    add_raw(8'h7F, 1'b1);
    add_raw(8'h01, 1'b0);
    add_raw(8'hDE, 1'b0);                          // hand id half done ...
    add_raw(8'hAD, 1'b0);
    add_raw(8'h39, 1'b1);                          // ... and dropped by a new start
    add_raw(8'h01, 1'b0);
    add_raw(8'h12, 1'b0);
    add_raw(8'h34, 1'b0);
    add_raw(8'h56, 1'b0);
    add_raw(8'h78, 1'b0);
    add_raw(8'h02, 1'b0);                          // unknown side, parsing goes on
    repeat (4) add_raw(8'hFF, 1'b0);               // confidence
    repeat (4) add_raw(8'h00, 1'b0);               // grab
    add_raw(8'h06, 1'b0);                          // one finger over the limit

    // random part: one large datagram, then mostly whole datagrams with some
    // cut short and some loose bytes in between
    build_datagram(1'b1);
    commit_frame(frame.size());
    while (datagram_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        build_datagram(1'b0);
        commit_frame(frame.size());
      end else if (pick < 88) begin
        build_datagram(1'b0);
        commit_frame($urandom_range(1, frame.size()));
        cut_datagrams++;
      end else begin
        repeat ($urandom_range(1, 6))
          add_raw(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
    quiet_from = byte_stream.size() - CALM_TAIL;

    // reset once, then released
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every iteration starts at a rising edge; ready is looked at on the
    // falling edge so the accepting edge is known without a race
    for (int idx = 0; idx < byte_stream.size(); idx++) begin
      calm <= (idx >= quiet_from);
      if (idx < quiet_from && $urandom_range(0, 11) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= byte_stream[idx];
      do @(negedge clk_i); while (in_ready_o !== 1'b1);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b0;

    // drain, then idle to catch anything stray
    do @(negedge clk_i); while (pending_count != 0);
    repeat (20) @(negedge clk_i);

    $display("drove %0d bytes: %0d datagrams, %0d of them cut short, plus loose bytes",
             byte_stream.size(), datagrams, cut_datagrams);
    $display("%0d field requests checked field by field", fields_checked);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result receiver: random stall bursts until the calm tail
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
